// File: hw/rtl/ngram_row_index_hash_top_assert.svh
// assertion macros for the ngram row index hash block
// both expect signals named clk and arst_n in the calling scope
`ifndef NGRAM_ROW_INDEX_HASH_TOP_ASSERT_SVH
`define NGRAM_ROW_INDEX_HASH_TOP_ASSERT_SVH

// same-cycle implication
`define NGR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ngram hash check failed");

// next-cycle implication
`define NGR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ngram hash check failed");

`endif

// File: hw/rtl/ngr_pkg.sv
package ngr_pkg;

	localparam int TOKEN_W    = 32;
	localparam int MOD_W      = 32;
	localparam int MULT_W     = 63;
	localparam int HASH_W     = 64;
	localparam int HEAD_OUT_W = 4;
	localparam int SEL_W      = 4;
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 64;

	localparam int unsigned BIGRAM_HEADS = 8;
	localparam logic [1:0]  CONTEXT_MAX  = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_HASH = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] CFG_END_TOKEN       = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MULT_CURRENT    = 8'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MULT_PREVIOUS   = 8'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_MULT_BEFORE_PREV = 8'd3;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

// File: hw/rtl/ngr_ram.sv
module ngr_ram #(
	parameter int WIDTH = 68,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/ngr_mul.sv
module ngr_mul
	import ngr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TOKEN_W-1:0] a,
	input  logic [MULT_W-1:0]  b,
	output unit_sts_t         sts,
	output logic [HASH_W-1:0] product
);

	localparam int CNT_W = $clog2(TOKEN_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TOKEN_W-1:0] a_q;
	logic [HASH_W-1:0]  b_q;
	logic [HASH_W-1:0]  acc_q;

	// one multiplier bit per cycle, product kept modulo 2^64
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(TOKEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= HASH_W'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			if (a_q[0]) begin
				acc_q <= acc_q + b_q;
			end
			a_q <= a_q >> 1;
			b_q <= b_q << 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = acc_q;

endmodule

// File: hw/rtl/ngr_div.sv
module ngr_div
	import ngr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [MOD_W-1:0]  divisor,
	output unit_sts_t         sts,
	output logic [MOD_W-1:0]  rem
);

	localparam int CNT_W = $clog2(HASH_W);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_SHIFT,
		DV_FIX
	} dv_state_t;

	dv_state_t        state_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [HASH_W-1:0] dvd_q;
	logic [MOD_W-1:0]  dsr_q;
	logic [MOD_W-1:0]  rem_q;

	logic [MOD_W:0] trial;
	logic           fits;
	logic [MOD_W:0] diff;

	assign trial = {rem_q, dvd_q[HASH_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DV_IDLE: begin
					if (start) begin
						state_q <= DV_SHIFT;
						cnt_q   <= '0;
					end
				end
				DV_SHIFT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(HASH_W - 1)) begin
						state_q <= DV_FIX;
					end
				end
				DV_FIX: begin
					state_q <= DV_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	// restoring division on the magnitude, one quotient bit per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			DV_IDLE: begin
				if (start) begin
					neg_q <= dividend[HASH_W-1];
					dvd_q <= dividend[HASH_W-1] ? (~dividend + 1'b1) : dividend;
					dsr_q <= divisor;
					rem_q <= '0;
				end
			end
			DV_SHIFT: begin
				rem_q <= fits ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
				dvd_q <= dvd_q << 1;
			end
			DV_FIX: begin
				// zero divisor gives zero, negative hash folds to the positive side
				if (dsr_q == '0) begin
					rem_q <= '0;
				end else if (neg_q && (rem_q != '0)) begin
					rem_q <= dsr_q - rem_q;
				end
			end
			default: ;
		endcase
	end

	assign sts.busy = (state_q != DV_IDLE);
	assign sts.done = done_q;
	assign rem      = rem_q;

endmodule

// File: hw/rtl/ngram_row_index_hash_top.sv
// n-gram row index hash
// input stream (s_*): one request per beat. s_tuser is the op: a load request writes one
// head's modulus and row offset, a hash request carries a token. a load gives no result;
// a load to a head at or above HEADS is dropped.
// output stream (m_*): each hash request gives HEADS results in head order, the head
// number on m_tuser, the row id on m_tdata, m_tlast on the final head.
// a hash request holds s_tready low until its last result is loaded: three bit-serial
// products of 32 steps each (plus start and done) build the bigram and trigram hashes,
// then each head takes a table read, start, 64 remainder steps, sign fix, done and
// output load.
// s_tready is high only while the sequencer is idle; the last result may still sit in
// the output register while the next request is taken.
// a stall on m_tready holds the current result and pauses the sequencer before the
// next result is loaded; nothing is dropped.
// configuration (cfg_*) writes the end token and the three multipliers, always ready;
// write it only while the block is idle.
// reset clears the context, sets the end token to 0 and the multipliers to 1; head
// tables hold nothing until loaded.
`include "ngram_row_index_hash_top_assert.svh"

module ngram_row_index_hash_top
	import ngr_pkg::*;
#(
	parameter int HEADS    = 16,
	parameter int ROW_BITS = 36
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	// head_sel, modulus, row_offset, token, zero pad
	input  logic [((SEL_W+MOD_W+ROW_BITS+TOKEN_W+7)/8)*8-1:0] s_tdata,
	// op
	input  logic                  s_tuser,

	output logic                  m_tvalid,
	input  logic                  m_tready,
	// row_id, zero pad
	output logic [((ROW_BITS+7)/8)*8-1:0] m_tdata,
	// head_out
	output logic [HEAD_OUT_W-1:0] m_tuser,
	output logic                  m_tlast,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int HW       = $clog2(HEADS);
	localparam int M_DATA_W = ((ROW_BITS + 7) / 8) * 8;
	localparam int MOD_LO   = SEL_W;
	localparam int OFF_LO   = SEL_W + MOD_W;
	localparam int TOK_LO   = SEL_W + MOD_W + ROW_BITS;
	localparam int ENTRY_W  = MOD_W + ROW_BITS;
	localparam int SUM_W    = (ROW_BITS > MOD_W) ? ROW_BITS : MOD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_GO,
		ST_MUL_RUN,
		ST_RD,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_OUT
	} state_t;

	state_t state_q;

	logic [TOKEN_W-1:0] end_token_q;
	logic [MULT_W-1:0]  mult_cur_q;
	logic [MULT_W-1:0]  mult_prev_q;
	logic [MULT_W-1:0]  mult_far_q;

	logic [TOKEN_W-1:0] prev_near_q;
	logic [TOKEN_W-1:0] prev_far_q;
	logic [1:0]         ctx_cnt_q;

	logic [TOKEN_W-1:0] tok_q;
	logic [TOKEN_W-1:0] near_q;
	logic [TOKEN_W-1:0] far_q;
	logic [1:0]         mul_idx_q;
	logic [HASH_W-1:0]  h1_q;
	logic [HASH_W-1:0]  h2_q;
	logic [HW-1:0]      head_q;
	logic [ROW_BITS-1:0] offset_q;

	logic                  m_tvalid_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [HEAD_OUT_W-1:0] head_out_q;
	logic                  last_q;

	logic [SEL_W-1:0]    in_sel;
	logic [MOD_W-1:0]    in_modulus;
	logic [ROW_BITS-1:0] in_offset;
	logic [TOKEN_W-1:0]  in_token;
	logic                in_accept;
	logic                hash_end_req;

	assign in_sel     = s_tdata[MOD_LO-1:0];
	assign in_modulus = s_tdata[OFF_LO-1:MOD_LO];
	assign in_offset  = s_tdata[TOK_LO-1:OFF_LO];
	assign in_token   = s_tdata[TOK_LO+TOKEN_W-1:TOK_LO];
	assign in_accept  = s_tvalid && s_tready;

	assign hash_end_req = in_accept && (s_tuser == OP_HASH) && (in_token == end_token_q);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// head table: {row offset, modulus}
	logic               ram_we;
	logic [HW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	assign ram_we    = in_accept && (s_tuser == OP_LOAD) && ({28'd0, in_sel} < HEADS);
	assign ram_waddr = HW'(in_sel);
	assign ram_wdata = {in_offset, in_modulus};

	ngr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HEADS)
	) u_head_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (state_q == ST_RD),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// serial multiplier, shared by the three products
	unit_sts_t          mul_sts;
	logic [TOKEN_W-1:0] mul_a;
	logic [MULT_W-1:0]  mul_b;
	logic [HASH_W-1:0]  mul_p;

	always_comb begin
		case (mul_idx_q)
			2'd0: begin
				mul_a = tok_q;
				mul_b = mult_cur_q;
			end
			2'd1: begin
				mul_a = near_q;
				mul_b = mult_prev_q;
			end
			default: begin
				mul_a = far_q;
				mul_b = mult_far_q;
			end
		endcase
	end

	ngr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_MUL_GO),
		.a      (mul_a),
		.b      (mul_b),
		.sts    (mul_sts),
		.product(mul_p)
	);

	// serial remainder unit, one head at a time
	unit_sts_t         div_sts;
	logic [HASH_W-1:0] div_hash;
	logic [MOD_W-1:0]  div_rem;

	assign div_hash = (32'(head_q) < BIGRAM_HEADS) ? h1_q : h2_q;

	ngr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_DIV_GO),
		.dividend(div_hash),
		.divisor (ram_rdata[MOD_W-1:0]),
		.sts     (div_sts),
		.rem     (div_rem)
	);

	logic [SUM_W-1:0] row_sum;
	logic [4:0]       head_wide;
	logic             out_free;

	assign row_sum   = SUM_W'(div_rem) + SUM_W'(offset_q);
	assign head_wide = 5'(head_q);
	assign out_free  = !m_tvalid_q || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_token_q <= '0;
			mult_cur_q  <= MULT_W'(1);
			mult_prev_q <= MULT_W'(1);
			mult_far_q  <= MULT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				CFG_END_TOKEN:        end_token_q <= cfg_data[TOKEN_W-1:0];
				CFG_MULT_CURRENT:     mult_cur_q  <= cfg_data[MULT_W-1:0];
				CFG_MULT_PREVIOUS:    mult_prev_q <= cfg_data[MULT_W-1:0];
				CFG_MULT_BEFORE_PREV: mult_far_q  <= cfg_data[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, context and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_near_q <= '0;
			prev_far_q  <= '0;
			ctx_cnt_q   <= '0;
			mul_idx_q   <= '0;
			head_q      <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (s_tuser == OP_HASH)) begin
						// empty context slots read as the end token
						tok_q     <= in_token;
						near_q    <= (ctx_cnt_q >= 2'd1) ? prev_near_q : end_token_q;
						far_q     <= (ctx_cnt_q >= CONTEXT_MAX) ? prev_far_q : end_token_q;
						mul_idx_q <= '0;
						head_q    <= '0;
						state_q   <= ST_MUL_GO;
						if (in_token == end_token_q) begin
							prev_near_q <= '0;
							prev_far_q  <= '0;
							ctx_cnt_q   <= '0;
						end else begin
							prev_far_q  <= prev_near_q;
							prev_near_q <= in_token;
							if (ctx_cnt_q < CONTEXT_MAX) begin
								ctx_cnt_q <= ctx_cnt_q + 1'b1;
							end
						end
					end
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL_RUN;
				end
				ST_MUL_RUN: begin
					if (mul_sts.done) begin
						mul_idx_q <= mul_idx_q + 1'b1;
						case (mul_idx_q)
							2'd0: begin
								h1_q    <= mul_p;
								state_q <= ST_MUL_GO;
							end
							2'd1: begin
								h1_q    <= h1_q ^ mul_p;
								state_q <= ST_MUL_GO;
							end
							default: begin
								h2_q    <= h1_q ^ mul_p;
								state_q <= ST_RD;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					offset_q <= ram_rdata[ENTRY_W-1:MOD_W];
					state_q  <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					if (div_sts.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						row_q      <= row_sum[ROW_BITS-1:0];
						head_out_q <= head_wide[HEAD_OUT_W-1:0];
						last_q     <= (head_q == HW'(HEADS - 1));
						head_q     <= head_q + 1'b1;
						state_q    <= (head_q == HW'(HEADS - 1)) ? ST_IDLE : ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(row_q);
	assign m_tuser  = head_out_q;
	assign m_tlast  = last_q;

	`NGR_ASSERT_IMP(a_units_exclusive, mul_sts.busy, !div_sts.busy)
	`NGR_ASSERT_IMP(a_idle_units_quiet, s_tready, !mul_sts.busy && !div_sts.busy)
	`NGR_ASSERT_NEXT(a_end_token_clears, hash_end_req, ctx_cnt_q == 2'd0)

endmodule
